FILE: rtl/core/dlut_pkg.sv
// types, bin bounds and reciprocal constants shared by the interpolating lut
package dlut_pkg;

	// field widths of the channels
	localparam int unsigned VAL_W = 31;
	localparam int unsigned BIN_W = 3;
	localparam int unsigned IDX_W = 10;

	// table geometry and number format
	localparam int unsigned FRAC_BITS       = 24;
	localparam int unsigned NUM_BINS        = 4;
	localparam int unsigned ENTRIES_PER_BIN = 1024;
	localparam int unsigned W_BITS          = 24;

	localparam int unsigned BSEL_W     = $clog2(NUM_BINS);
	localparam int unsigned POS_W      = $clog2(ENTRIES_PER_BIN);
	localparam int unsigned HALF_W     = POS_W - 1;
	localparam int unsigned BANK_AW    = 1 + BSEL_W + HALF_W;
	localparam int unsigned BANK_DEPTH = (2 * NUM_BINS * ENTRIES_PER_BIN) / 2;

	localparam int unsigned BOUND_W  = 32;
	localparam int unsigned X_W      = POS_W + W_BITS;
	localparam int unsigned RECIP_SH = VAL_W;
	localparam int unsigned RECIP_W  = 45;
	localparam int unsigned RLO_W    = 16;
	localparam int unsigned RHI_W    = RECIP_W - RLO_W;
	localparam int unsigned NLO_W    = BOUND_W - W_BITS;
	localparam int unsigned NUM_W    = 96;

	// item kinds
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic [POS_W-1:0] LAST_Q = POS_W'(ENTRIES_PER_BIN - 2);

	typedef logic [BOUND_W-1:0] bound_t;
	typedef logic [RECIP_W-1:0] recip_t;

	localparam bound_t ONE_FX = bound_t'(1) << FRAC_BITS;

	// upper bounds 0.1, 1, 10, 100 in the fixed format, 0.1 rounded half up
	localparam bound_t BIN_HI [NUM_BINS] = '{
		(ONE_FX + bound_t'(5)) / bound_t'(10),
		ONE_FX,
		ONE_FX * bound_t'(10),
		ONE_FX * bound_t'(100)
	};
	localparam bound_t BIN_LO [NUM_BINS] = '{
		bound_t'(0), BIN_HI[0], BIN_HI[1], BIN_HI[2]
	};
	localparam bound_t BIN_DEN [NUM_BINS] = '{
		BIN_HI[0] - BIN_LO[0],
		BIN_HI[1] - BIN_LO[1],
		BIN_HI[2] - BIN_LO[2],
		BIN_HI[3] - BIN_LO[3]
	};
	localparam bound_t TOP_BOUND = BIN_HI[NUM_BINS-1];

	// floor((ENTRIES_PER_BIN - 1) * 2^(W_BITS + RECIP_SH) / den) per bin
	localparam logic [NUM_W-1:0] RECIP_NUM =
		NUM_W'(ENTRIES_PER_BIN - 1) << (W_BITS + RECIP_SH);
	localparam recip_t RECIP [NUM_BINS] = '{
		recip_t'(RECIP_NUM / NUM_W'(BIN_DEN[0])),
		recip_t'(RECIP_NUM / NUM_W'(BIN_DEN[1])),
		recip_t'(RECIP_NUM / NUM_W'(BIN_DEN[2])),
		recip_t'(RECIP_NUM / NUM_W'(BIN_DEN[3]))
	};

	typedef struct packed {
		logic             kind;
		logic             table_sel;
		logic [BIN_W-1:0] bin;
		logic [IDX_W-1:0] entry_index;
		logic [VAL_W-1:0] entry_value;
		logic [VAL_W-1:0] sample;
	} cmd_t;

	// table access of one item, as issued to the entry memories
	typedef struct packed {
		logic              valid;
		logic              lookup;
		logic              table_sel;
		logic              wr_ok;
		logic [BSEL_W-1:0] bin;
		logic [POS_W-1:0]  pos;
		logic [W_BITS-1:0] weight;
		logic              top;
		logic              clamped;
		logic [VAL_W-1:0]  entry_value;
	} loc_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] result;
		logic             clamped;
	} blend_t;

endpackage

FILE: rtl/core/dlut_in_if.sv
// input channel: table writes and lookups
interface dlut_in_if import dlut_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic             table_sel;
	logic [BIN_W-1:0] bin;
	logic [IDX_W-1:0] entry_index;
	logic [VAL_W-1:0] entry_value;
	logic [VAL_W-1:0] sample;

	modport source (
		output valid, kind, table_sel, bin, entry_index, entry_value, sample,
		input  ready
	);
	modport sink (
		input  valid, kind, table_sel, bin, entry_index, entry_value, sample,
		output ready
	);
endinterface

FILE: rtl/core/dlut_out_if.sv
// output channel: interpolated results
interface dlut_out_if import dlut_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] result;
	logic             clamped;

	modport source (output valid, result, clamped, input ready);
	modport sink (input valid, result, clamped, output ready);
endinterface

FILE: rtl/core/decade_binned_interp_lut_top.sv
// Interpolating lookup table for a transfer curve and its inverse, bins bounded by
// powers of ten (0.1, 1, 10, 100), unsigned Q7.24 throughout. A write item stores one
// entry; for a lookup item the result is offered from an output register. One item
// is taken every clock; the pipeline holds only when a result waits at the output and
// the last stage is occupied. The bin offset is divided exactly by the bin width with a
// reciprocal multiply, split into two partial products, and a one-step remainder
// correction (stages 1-5). Each table lives in two RAM banks split by entry parity, so
// both neighbors come out of a single read (stage 6); writes and reads go to the RAMs
// from the same stage, so a lookup always sees every earlier write. Entries read
// before they are written are undefined.
module decade_binned_interp_lut_top import dlut_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	dlut_in_if.sink    cmd,
	dlut_out_if.source rsp
);
	logic               advance;
	cmd_t               cmd_item;
	loc_t               loc;
	blend_t             blend;

	logic [BANK_AW-1:0] rd_even_addr, rd_odd_addr, wr_addr;
	logic [HALF_W-1:0]  half;
	logic               odd_pos;
	logic               wr_en;
	logic [VAL_W-1:0]   even_rd, odd_rd;

	logic               out_valid_q;
	logic [VAL_W-1:0]   result_q;
	logic               clamped_q;

	// hold everything only if the finished result cannot move to the output
	assign advance   = !(out_valid_q && !rsp.ready && blend.valid);
	assign cmd.ready = advance;

	always_comb begin
		cmd_item.kind        = cmd.kind;
		cmd_item.table_sel   = cmd.table_sel;
		cmd_item.bin         = cmd.bin;
		cmd_item.entry_index = cmd.entry_index;
		cmd_item.entry_value = cmd.entry_value;
		cmd_item.sample      = cmd.sample;
	end

	dlut_locate u_locate (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (cmd.valid),
		.cmd      (cmd_item),
		.loc      (loc)
	);

	// bank address is {table, bin, position / 2}, the even read rounding up
	always_comb begin
		half         = loc.pos[POS_W-1:1];
		odd_pos      = loc.pos[0];
		rd_odd_addr  = {loc.table_sel, loc.bin, half};
		rd_even_addr = {loc.table_sel, loc.bin, half + HALF_W'(odd_pos)};
		wr_addr      = {loc.table_sel, loc.bin, half};
		wr_en        = advance && loc.valid && !loc.lookup && loc.wr_ok;
	end

	dlut_ram #(
		.WIDTH (VAL_W),
		.DEPTH (BANK_DEPTH)
	) u_even_ram (
		.clk   (clk),
		.we    (wr_en && !odd_pos),
		.waddr (wr_addr),
		.wdata (loc.entry_value),
		.re    (advance),
		.raddr (rd_even_addr),
		.rdata (even_rd)
	);

	dlut_ram #(
		.WIDTH (VAL_W),
		.DEPTH (BANK_DEPTH)
	) u_odd_ram (
		.clk   (clk),
		.we    (wr_en && odd_pos),
		.waddr (wr_addr),
		.wdata (loc.entry_value),
		.re    (advance),
		.raddr (rd_odd_addr),
		.rdata (odd_rd)
	);

	dlut_interp u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.loc     (loc),
		.even_rd (even_rd),
		.odd_rd  (odd_rd),
		.blend   (blend)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (blend.valid && advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (blend.valid && advance) begin
			result_q  <= blend.result;
			clamped_q <= blend.clamped;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.result  = result_q;
	assign rsp.clamped = clamped_q;
endmodule

FILE: rtl/core/dlut_ram.sv
// generic simple dual port ram, one write and one registered read port
module dlut_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/core/dlut_locate.sv
// bin select and exact division to entry position and weight, five stages
module dlut_locate import dlut_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic in_valid,
	input  cmd_t cmd,
	output loc_t loc
);
	typedef struct packed {
		logic              lookup;
		logic              table_sel;
		logic              wr_ok;
		logic [BSEL_W-1:0] bin;
		logic [IDX_W-1:0]  entry_index;
		logic [VAL_W-1:0]  entry_value;
		logic              top;
		logic              clamped;
	} meta_t;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	cmd_t                     cmd_s1;
	meta_t                    meta_s2, meta_s3, meta_s4, meta_s5;
	logic [VAL_W-1:0]         offset_s2;
	logic [VAL_W+RHI_W-1:0]   pp_hi_s3;
	logic [VAL_W+RLO_W-1:0]   pp_lo_s3;
	logic [NLO_W-1:0]         nlo_s3, nlo_s4, nlo_s5;
	logic [X_W-1:0]           xe_s4, xe_s5;
	logic [BOUND_W-1:0]       prod_s5;

	meta_t                    meta1;
	logic [BSEL_W-1:0]        bsel;
	logic [VAL_W-1:0]         offset;
	recip_t                   recip;
	logic [VAL_W+RHI_W-1:0]   pp_hi;
	logic [VAL_W+RLO_W-1:0]   pp_lo;
	logic [NLO_W-1:0]         nlo;
	logic [RECIP_W+VAL_W-1:0] est_sum;
	logic [X_W-1:0]           xe;
	logic [BOUND_W-1:0]       prod;
	logic [BOUND_W-1:0]       rem;
	logic [X_W-1:0]           xfix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: bin from the fixed bounds, offset into the bin
	always_comb begin
		bsel = '0;
		for (int k = 0; k < NUM_BINS - 1; k++) begin
			if (BOUND_W'(cmd_s1.sample) >= BIN_HI[BSEL_W'(k)]) begin
				bsel = BSEL_W'(k + 1);
			end
		end
		offset = VAL_W'(BOUND_W'(cmd_s1.sample) - BIN_LO[bsel]);

		meta1.lookup      = (cmd_s1.kind == KIND_LOOKUP);
		meta1.table_sel   = cmd_s1.table_sel;
		meta1.wr_ok       = (cmd_s1.bin < BIN_W'(NUM_BINS)) &&
			({1'b0, cmd_s1.entry_index} < (IDX_W+1)'(ENTRIES_PER_BIN));
		meta1.bin         = (cmd_s1.kind == KIND_LOOKUP) ? bsel : BSEL_W'(cmd_s1.bin);
		meta1.entry_index = cmd_s1.entry_index;
		meta1.entry_value = cmd_s1.entry_value;
		meta1.top         = (BOUND_W'(cmd_s1.sample) >= TOP_BOUND);
		meta1.clamped     = meta1.top || (cmd_s1.sample == '0);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1    <= cmd;
			meta_s2   <= meta1;
			offset_s2 <= offset;
		end
	end

	// stage 2: offset times reciprocal, split in two partial products
	always_comb begin
		recip = RECIP[meta_s2.bin];
		pp_hi = {RHI_W'(0), offset_s2} * {VAL_W'(0), recip[RECIP_W-1:RLO_W]};
		pp_lo = {RLO_W'(0), offset_s2} * {VAL_W'(0), recip[RLO_W-1:0]};
		// low bits of offset * (entries - 1), needed for the remainder check
		nlo   = NLO_W'(offset_s2[NLO_W-1:0] * NLO_W'(ENTRIES_PER_BIN - 1));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pp_hi_s3 <= pp_hi;
			pp_lo_s3 <= pp_lo;
			nlo_s3   <= nlo;
			meta_s3  <= meta_s2;
		end
	end

	// stage 3: estimate, never above the exact quotient and at most one below
	always_comb begin
		est_sum = {pp_hi_s3, RLO_W'(0)} + (RECIP_W+VAL_W)'(pp_lo_s3);
		xe      = X_W'(est_sum >> RECIP_SH);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			xe_s4   <= xe;
			nlo_s4  <= nlo_s3;
			meta_s4 <= meta_s3;
		end
	end

	// stage 4: low word of estimate * den, the remainder fits in one word
	always_comb begin
		prod = BOUND_W'(xe_s4[BOUND_W-1:0] * BIN_DEN[meta_s4.bin]);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			xe_s5   <= xe_s4;
			prod_s5 <= prod;
			nlo_s5  <= nlo_s4;
			meta_s5 <= meta_s4;
		end
	end

	// stage 5: correct by one, split into entry position and weight
	always_comb begin
		rem  = {nlo_s5, W_BITS'(0)} - prod_s5;
		xfix = xe_s5 + X_W'(rem >= BIN_DEN[meta_s5.bin]);

		loc.valid       = v_s5;
		loc.lookup      = meta_s5.lookup;
		loc.table_sel   = meta_s5.table_sel;
		loc.wr_ok       = meta_s5.wr_ok;
		loc.bin         = meta_s5.bin;
		loc.top         = meta_s5.top;
		loc.clamped     = meta_s5.clamped;
		loc.entry_value = meta_s5.entry_value;
		loc.pos         = xfix[X_W-1:W_BITS];
		loc.weight      = xfix[W_BITS-1:0];
		if (loc.pos > LAST_Q || meta_s5.top) begin
			loc.pos    = LAST_Q;
			loc.weight = '0;
		end
		if (!meta_s5.lookup) begin
			loc.pos    = POS_W'(meta_s5.entry_index);
			loc.weight = '0;
		end
	end
endmodule

FILE: rtl/core/dlut_interp.sv
// neighbor select and linear blend of the two entries read
module dlut_interp import dlut_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  loc_t             loc,
	input  logic [VAL_W-1:0] even_rd,
	input  logic [VAL_W-1:0] odd_rd,
	output blend_t           blend
);
	localparam int unsigned DIFF_W = VAL_W + 1;
	localparam int unsigned PROD_W = DIFF_W + W_BITS + 1;
	localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(1) << (W_BITS - 1);

	logic                     v_s6, v_s7;
	logic                     odd_s6, top_s6, clamped_s6;
	logic [W_BITS-1:0]        weight_s6;
	logic [VAL_W-1:0]         t0_s7, t1_s7;
	logic signed [PROD_W-1:0] prod_s7;
	logic                     top_s7, clamped_s7;

	logic [VAL_W-1:0]         t0, t1;
	logic signed [DIFF_W-1:0] diff;
	logic signed [W_BITS:0]   wsig;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] step;
	logic [BOUND_W-1:0]       mix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (advance) begin
			v_s6 <= loc.valid && loc.lookup;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			odd_s6     <= loc.pos[0];
			weight_s6  <= loc.weight;
			top_s6     <= loc.top;
			clamped_s6 <= loc.clamped;
		end
	end

	// stage 6: lower entry sits in the bank of the position's parity
	always_comb begin
		t0   = odd_s6 ? odd_rd : even_rd;
		t1   = odd_s6 ? even_rd : odd_rd;
		diff = $signed({1'b0, t1}) - $signed({1'b0, t0});
		wsig = $signed({1'b0, weight_s6});
		prod = diff * wsig;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			t0_s7      <= t0;
			t1_s7      <= t1;
			prod_s7    <= prod;
			top_s7     <= top_s6;
			clamped_s7 <= clamped_s6;
		end
	end

	// stage 7: t0 + round((t1 - t0) * w), top clamp takes the last entry
	always_comb begin
		step = (prod_s7 + ROUND_C) >>> W_BITS;
		mix  = BOUND_W'({1'b0, t0_s7}) + BOUND_W'(step);

		blend.valid   = v_s7;
		blend.clamped = clamped_s7;
		blend.result  = top_s7 ? t1_s7 : mix[VAL_W-1:0];
	end
endmodule

FILE: sim/decade_binned_interp_lut_top_tb.sv
// testbench for the decade-binned interpolating lut: table writes, lookups, result checks
module decade_binned_interp_lut_top_tb;
	import dlut_pkg::*;

	localparam int unsigned TABLE_DEPTH = NUM_BINS * ENTRIES_PER_BIN;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned ITEM_TARGET = 1500;
	localparam int unsigned MAX_GAP     = 12;
	localparam bit [VAL_W-1:0] VAL_MAX  = '1;

	typedef struct {
		bit [VAL_W-1:0] result;
		bit             clamped;
	} curve_point_t;

	class curve_scoreboard;
		bit [VAL_W-1:0] curve [2][TABLE_DEPTH];
		curve_point_t   predicted_points [$];
		int unsigned    errors;

		// upper bound of a bin, 10^(b + 3 - NUM_BINS) in the fixed format, half up
		static function bit [63:0] decade_hi(int unsigned b);
			int         e;
			bit [63:0]  p;
			e = int'(b) + 3 - int'(NUM_BINS);
			p = 64'd1;
			if (e >= 0) begin
				repeat (e) p = p * 64'd10;
				return p << FRAC_BITS;
			end
			repeat (-e) p = p * 64'd10;
			return ((64'd1 << FRAC_BITS) + p / 64'd2) / p;
		endfunction

		static function bit [63:0] decade_lo(int unsigned b);
			return (b == 0) ? 64'd0 : decade_hi(b - 1);
		endfunction

		// left neighbor address and blend weight; clamped samples use a fixed pair
		static function void locate(input bit [VAL_W-1:0] s, output int unsigned addr,
				output bit [63:0] weight, output bit clamp);
			int unsigned b;
			bit [63:0]   lo, den, num, q, r;
			addr   = 0;
			weight = 64'd0;
			clamp  = 1'b1;
			if (s == 0)
				return;
			if (s >= decade_hi(NUM_BINS - 1)) begin
				// full weight on the right entry gives the last entry exactly
				addr   = TABLE_DEPTH - 2;
				weight = 64'd1 << W_BITS;
				return;
			end
			clamp = 1'b0;
			b = 0;
			while (b + 1 < NUM_BINS && s >= decade_hi(b))
				b++;
			lo  = decade_lo(b);
			den = decade_hi(b) - lo;
			num = (64'(s) - lo) * 64'(ENTRIES_PER_BIN - 1);
			q   = num / den;
			r   = num % den;
			if (q > ENTRIES_PER_BIN - 2) begin
				q = ENTRIES_PER_BIN - 2;
				r = 64'd0;
			end
			weight = (r << W_BITS) / den;
			addr   = b * ENTRIES_PER_BIN + int'(q);
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void take_item(cmd_t c);
			int unsigned  addr;
			bit [63:0]    w, t0, t1, blend;
			bit           clamp;
			curve_point_t p;
			if (c.kind == KIND_WRITE) begin
				if (c.bin < NUM_BINS && c.entry_index < ENTRIES_PER_BIN)
					curve[c.table_sel][c.bin * ENTRIES_PER_BIN + c.entry_index] = c.entry_value;
				return;
			end
			locate(c.sample, addr, w, clamp);
			t0 = 64'(curve[c.table_sel][addr]);
			t1 = 64'(curve[c.table_sel][addr + 1]);
			blend = (t0 * ((64'd1 << W_BITS) - w) + t1 * w + (64'd1 << (W_BITS - 1))) >> W_BITS;
			p.result  = blend[VAL_W-1:0];
			p.clamped = clamp;
			predicted_points.push_back(p);
		endfunction

		function void check_result(bit [VAL_W-1:0] result, bit clamped);
			curve_point_t p;
			if (predicted_points.size() == 0) begin
				report($sformatf("unexpected result %h clamped %b", result, clamped));
				return;
			end
			p = predicted_points.pop_front();
			if (result !== p.result || clamped !== p.clamped)
				report($sformatf("mismatch: result %h clamped %b, expected %h clamped %b",
					result, clamped, p.result, p.clamped));
		endfunction

		function int unsigned outstanding();
			return predicted_points.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dlut_in_if  cmd_if ();
	dlut_out_if rsp_if ();

	decade_binned_interp_lut_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	curve_scoreboard board;
	bit              written [2][TABLE_DEPTH];
	bit              calm;
	int unsigned     table_items;
	int unsigned     cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			board.check_result(rsp_if.result, rsp_if.clamped);
	end

	// result side: random stall before each transfer, none while calm
	initial begin
		int unsigned gap;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (gap != 0) begin
				rsp_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_if.ready = 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			@(negedge clk);
		end
	end

	function automatic bit [VAL_W-1:0] any_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return VAL_MAX;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic cmd_t write_cmd(bit sel, bit [BIN_W-1:0] b, bit [IDX_W-1:0] idx,
			bit [VAL_W-1:0] value);
		cmd_t c;
		c.kind        = KIND_WRITE;
		c.table_sel   = sel;
		c.bin         = b;
		c.entry_index = idx;
		c.entry_value = value;
		c.sample      = VAL_W'($urandom);
		return c;
	endfunction

	function automatic cmd_t lookup_cmd(bit sel, bit [VAL_W-1:0] s);
		cmd_t c;
		c.kind        = KIND_LOOKUP;
		c.table_sel   = sel;
		c.bin         = BIN_W'($urandom);
		c.entry_index = IDX_W'($urandom);
		c.entry_value = VAL_W'($urandom);
		c.sample      = s;
		return c;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_cmd(cmd_t c);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			cmd_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_if.kind        = c.kind;
		cmd_if.table_sel   = c.table_sel;
		cmd_if.bin         = c.bin;
		cmd_if.entry_index = c.entry_index;
		cmd_if.entry_value = c.entry_value;
		cmd_if.sample      = c.sample;
		cmd_if.valid       = 1'b1;
		do @(posedge clk); while (!cmd_if.ready);
		board.take_item(c);
		if (c.kind == KIND_LOOKUP || c.bin < NUM_BINS)
			table_items++;
		@(negedge clk);
	endtask

	task automatic put_entry(bit sel, int unsigned addr, bit [VAL_W-1:0] value);
		written[sel][addr] = 1'b1;
		send_cmd(write_cmd(sel, BIN_W'(addr / ENTRIES_PER_BIN), IDX_W'(addr % ENTRIES_PER_BIN),
			value));
	endtask

	// fills both neighbors first where needed; refresh rewrites them right before the read
	task automatic lookup(bit sel, bit [VAL_W-1:0] s, bit refresh);
		int unsigned addr;
		bit [63:0]   w;
		bit          clamp;
		curve_scoreboard::locate(s, addr, w, clamp);
		for (int k = 0; k < 2; k++) begin
			if (refresh || !written[sel][addr + k])
				put_entry(sel, addr + k, any_value());
		end
		send_cmd(lookup_cmd(sel, s));
	endtask

	function automatic bit [VAL_W-1:0] draw_sample();
		int unsigned b;
		bit [63:0]   lo, hi, top;
		top = curve_scoreboard::decade_hi(NUM_BINS - 1);
		b   = $urandom_range(0, NUM_BINS - 1);
		lo  = curve_scoreboard::decade_lo(b);
		hi  = curve_scoreboard::decade_hi(b);
		case ($urandom_range(0, 15))
			0: return '0;
			1: return VAL_W'(top + 64'($urandom_range(0, 32'(64'(VAL_MAX) - top))));
			2: return VAL_W'((b == 0) ? 64'd1 : lo);
			3: return VAL_W'(hi - 64'd1);
			default: return VAL_W'(lo + 64'($urandom_range(0, 32'(hi - lo - 64'd1))));
		endcase
	endfunction

	initial begin
		bit [63:0] top, tenth, one, ten;
		cmd_t      c;
		arst_n = 1'b0;
		cmd_if.valid       = 1'b0;
		cmd_if.kind        = KIND_WRITE;
		cmd_if.table_sel   = 1'b0;
		cmd_if.bin         = '0;
		cmd_if.entry_index = '0;
		cmd_if.entry_value = '0;
		cmd_if.sample      = '0;
		calm  = 1'b0;
		board = new;
		top   = curve_scoreboard::decade_hi(NUM_BINS - 1);
		tenth = curve_scoreboard::decade_hi(0);
		one   = curve_scoreboard::decade_hi(1);
		ten   = curve_scoreboard::decade_hi(2);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// field extremes, clamping at both ends, ignored writes and bin boundaries
		put_entry(1'b0, 0, '0);
		put_entry(1'b0, 1, VAL_MAX);
		lookup(1'b0, '0, 1'b0);
		lookup(1'b0, VAL_W'(1), 1'b0);
		send_cmd(write_cmd(1'b0, BIN_W'(NUM_BINS), '0, VAL_MAX));
		send_cmd(write_cmd(1'b1, '1, '1, VAL_MAX));
		lookup(1'b0, '0, 1'b0);
		lookup(1'b0, VAL_W'(top), 1'b0);
		lookup(1'b0, VAL_MAX, 1'b0);
		lookup(1'b0, VAL_W'(top - 64'd1), 1'b0);
		lookup(1'b0, VAL_W'(tenth - 64'd1), 1'b0);
		lookup(1'b0, VAL_W'(tenth), 1'b0);
		lookup(1'b0, VAL_W'(one), 1'b0);
		lookup(1'b1, VAL_W'(ten), 1'b0);
		lookup(1'b1, '0, 1'b0);
		lookup(1'b1, VAL_W'(top), 1'b0);

		while (table_items < ITEM_TARGET) begin
			if ($urandom_range(0, 99) == 0)
				calm = !calm;
			case ($urandom_range(0, 9))
				0, 1: begin
					c = write_cmd(1'($urandom), BIN_W'($urandom), IDX_W'($urandom), any_value());
					if (c.bin < NUM_BINS)
						written[c.table_sel][c.bin * ENTRIES_PER_BIN + c.entry_index] = 1'b1;
					send_cmd(c);
				end
				2: lookup(1'($urandom), draw_sample(), 1'b1);
				default: lookup(1'($urandom), draw_sample(), 1'b0);
			endcase
		end
		cmd_if.valid = 1'b0;

		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/dlut_pkg.sv
rtl/core/dlut_in_if.sv
rtl/core/dlut_out_if.sv
rtl/core/dlut_ram.sv
rtl/core/dlut_locate.sv
rtl/core/dlut_interp.sv
rtl/core/decade_binned_interp_lut_top.sv
sim/decade_binned_interp_lut_top_tb.sv
